@@ rtl/htf_pkg.sv @@
// shared constants, types and saturation helpers for the holt trend forecaster
// no dependencies; every rtl file imports this package
`default_nettype none

package htf_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS       = 16;   // q31.16 level and trend
  localparam int GAIN_FRAC       = 16;   // gains are unsigned q1.16
  localparam int GAIN_W          = 17;
  localparam int HOR_W           = 4;
  localparam int Q_W             = 48;   // level, trend, forecast
  localparam int RES_W           = 24;   // residual fed to stage two
  localparam int WIDE_W          = 54;   // headroom before saturation
  localparam int DIFF_W          = 50;   // differences and magnitudes
  localparam int CHUNK_W         = 25;   // multiplier b operand
  localparam int ACC_W           = 68;
  localparam int HACC_W          = Q_W + HOR_W;
  localparam int QMAG_W          = DIFF_W + 1;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;
  localparam int REG_IDX_W       = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE        = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] LEVEL_GAIN_RST  = GAIN_W'(26214);
  localparam logic [GAIN_W-1:0] TREND_GAIN_RST  = GAIN_W'(39322);
  localparam logic [HOR_W-1:0]  HORIZON_RST     = HOR_W'(1);
  localparam logic [ACC_W-1:0]  RND_BIAS        = ACC_W'(1) << (GAIN_FRAC - 1);

  localparam logic [REG_IDX_W-1:0] REG_LEVEL_GAIN    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TREND_GAIN    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HORIZON       = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RESIDUAL_MODE = 2'd3;

  typedef struct packed {
    logic [GAIN_W-1:0] level_gain;
    logic [GAIN_W-1:0] trend_gain;
    logic [HOR_W-1:0]  horizon;
    logic              residual_mode;
  } cfg_t;

  typedef struct packed {
    logic en;     // accumulate this cycle
    logic start;  // restart from the bias instead of the old sum
    logic rnd;    // bias is half an lsb of the gain product
    logic hi;     // b operand is the upper chunk
  } mac_cmd_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[WIDE_W-1:Q_W-1];
    all_zero = ~|v[WIDE_W-1:Q_W-1];
    if (all_one || all_zero) begin
      return v[Q_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [DIFF_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[DIFF_W-1:RES_W-1];
    all_zero = ~|v[DIFF_W-1:RES_W-1];
    if (all_one || all_zero) begin
      return v[RES_W-1:0];
    end else if (v[DIFF_W-1]) begin
      return {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      return {1'b0, {(RES_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/htf_cfg.sv @@
// apb register file: level gain, trend gain, horizon, residual mode
// depends on htf_pkg
`default_nettype none

module htf_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [htf_pkg::ADDR_W-1:0] paddr,
  input  logic [htf_pkg::DATA_W-1:0] pwdata,
  output logic [htf_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output htf_pkg::cfg_t              cfg
);
  import htf_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;
  logic [GAIN_W-1:0]    wgain;
  logic [GAIN_W-1:0]    gain_clamped;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign wgain  = pwdata[GAIN_W-1:0];
  // gains above one are held at one
  assign gain_clamped = (wgain > GAIN_ONE) ? GAIN_ONE : wgain;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_gain    <= LEVEL_GAIN_RST;
      cfg.trend_gain    <= TREND_GAIN_RST;
      cfg.horizon       <= HORIZON_RST;
      cfg.residual_mode <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_LEVEL_GAIN:    cfg.level_gain    <= gain_clamped;
        REG_TREND_GAIN:    cfg.trend_gain    <= gain_clamped;
        REG_HORIZON:       cfg.horizon       <= pwdata[HOR_W-1:0];
        REG_RESIDUAL_MODE: cfg.residual_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEVEL_GAIN:    prdata = DATA_W'(cfg.level_gain);
      REG_TREND_GAIN:    prdata = DATA_W'(cfg.trend_gain);
      REG_HORIZON:       prdata = DATA_W'(cfg.horizon);
      REG_RESIDUAL_MODE: prdata = DATA_W'(cfg.residual_mode);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/htf_mac.sv @@
// shared 17x25 unsigned multiply-accumulate, one partial product per cycle while cmd.en is high
// depends on htf_pkg
`default_nettype none

module htf_mac (
  input  logic                        clk,
  input  htf_pkg::mac_cmd_t           cmd,
  input  logic [htf_pkg::GAIN_W-1:0]  op_a,
  input  logic [htf_pkg::CHUNK_W-1:0] op_b,
  output logic [htf_pkg::ACC_W-1:0]   acc
);
  import htf_pkg::*;

  logic [GAIN_W+CHUNK_W-1:0] prod;
  logic [ACC_W-1:0]          prod_sh;
  logic [ACC_W-1:0]          base;

  assign prod    = op_a * op_b;
  assign prod_sh = cmd.hi ? {{(ACC_W-GAIN_W-2*CHUNK_W){1'b0}}, prod, {CHUNK_W{1'b0}}}
                          : ACC_W'(prod);
  assign base    = cmd.start ? (cmd.rnd ? RND_BIAS : '0) : acc;

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      acc <= base + prod_sh;
    end
  end

endmodule

`default_nettype wire

@@ rtl/htf_seq.sv @@
// sequencer and datapath for both smoothing stages, stage state and output register
// depends on htf_pkg; drives the shared multiplier in htf_mac
`default_nettype none

module htf_seq #(
  parameter int SAMPLE_BITS = htf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  htf_pkg::cfg_t                      cfg,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  input  logic                               series_start,
  input  logic                               in_valid,
  output logic                               in_ready,
  output logic signed [htf_pkg::Q_W-1:0]     forecast,
  output logic signed [htf_pkg::Q_W-1:0]     level_now,
  output logic signed [htf_pkg::Q_W-1:0]     trend_now,
  output logic                               out_valid,
  input  logic                               out_ready,
  output htf_pkg::mac_cmd_t                  mac_cmd,
  output logic [htf_pkg::GAIN_W-1:0]         mac_a,
  output logic [htf_pkg::CHUNK_W-1:0]        mac_b,
  input  logic [htf_pkg::ACC_W-1:0]          mac_acc
);
  import htf_pkg::*;

  localparam int VW = (SAMPLE_BITS > RES_W) ? SAMPLE_BITS : RES_W;
  localparam int SW = 5;

  localparam logic [SW-1:0] S_IDLE   = 5'd0;
  localparam logic [SW-1:0] S_LOAD   = 5'd1;
  localparam logic [SW-1:0] S_INIT   = 5'd2;
  localparam logic [SW-1:0] S_TRINIT = 5'd3;
  localparam logic [SW-1:0] S_PREP   = 5'd4;
  localparam logic [SW-1:0] S_FC0    = 5'd5;
  localparam logic [SW-1:0] S_FC1    = 5'd6;
  localparam logic [SW-1:0] S_FCF    = 5'd7;
  localparam logic [SW-1:0] S_L0     = 5'd8;
  localparam logic [SW-1:0] S_L1     = 5'd9;
  localparam logic [SW-1:0] S_LF     = 5'd10;
  localparam logic [SW-1:0] S_TD0    = 5'd11;
  localparam logic [SW-1:0] S_TD1    = 5'd12;
  localparam logic [SW-1:0] S_T0     = 5'd13;
  localparam logic [SW-1:0] S_T1     = 5'd14;
  localparam logic [SW-1:0] S_TF     = 5'd15;
  localparam logic [SW-1:0] S_RES0   = 5'd16;
  localparam logic [SW-1:0] S_RES1   = 5'd17;
  localparam logic [SW-1:0] S_FIN    = 5'd18;

  logic [SW-1:0] state;
  logic          stg;
  logic          have_res;

  // per-stage state
  logic signed [Q_W-1:0] lvl  [2];
  logic signed [Q_W-1:0] trd  [2];
  logic signed [VW-1:0]  prv  [2];
  logic [1:0]            seen [2];

  // working registers of the stage in progress
  logic signed [VW-1:0]     v;
  logic signed [Q_W-1:0]    cl;
  logic signed [Q_W-1:0]    ct;
  logic signed [VW-1:0]     cp;
  logic signed [DIFF_W-1:0] tmp;
  logic [DIFF_W-1:0]        mag;
  logic                     neg;
  logic signed [Q_W-1:0]    fc;
  logic signed [Q_W-1:0]    nl;
  logic signed [Q_W-1:0]    res_fc;
  logic signed [Q_W-1:0]    res_l;
  logic signed [Q_W-1:0]    res_t;

  logic signed [WIDE_W-1:0]       vq;
  logic signed [DIFF_W-1:0]       cpq;
  logic signed [VW:0]             td;
  logic signed [WIDE_W-1:0]       trinit;
  logic signed [WIDE_W-1:0]       add_base;
  logic signed [WIDE_W-1:0]       add_mag;
  logic signed [WIDE_W-1:0]       add_out;
  logic signed [Q_W-1:0]          sat_out;
  logic signed [DIFF_W-1:0]       dif_a;
  logic signed [DIFF_W-1:0]       dif_b;
  logic                           d_neg;
  logic [DIFF_W-1:0]              d_mag;
  logic [QMAG_W-1:0]              qmag;
  logic signed [DIFF_W-1:0]       rsh;
  logic                           rcorr;
  logic signed [DIFF_W-1:0]       rint;
  logic                           out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign vq     = {{(WIDE_W-VW-FRAC_BITS){v[VW-1]}}, v, {FRAC_BITS{1'b0}}};
  assign cpq    = {{(DIFF_W-VW-FRAC_BITS){cp[VW-1]}}, cp, {FRAC_BITS{1'b0}}};
  assign td     = (VW+1)'(v) - (VW+1)'(cp);
  assign trinit = {{(WIDE_W-VW-1-FRAC_BITS){td[VW]}}, td, {FRAC_BITS{1'b0}}};
  assign qmag   = mac_acc[GAIN_FRAC +: QMAG_W];

  // signed add of a magnitude: forecast, new level and new trend
  always_comb begin
    case (state)
      S_FCF:   add_base = WIDE_W'(cl);
      S_LF:    add_base = WIDE_W'(tmp);
      default: add_base = WIDE_W'(ct);
    endcase
    if (state == S_FCF) begin
      add_mag = $signed({{(WIDE_W-HACC_W){1'b0}}, mac_acc[HACC_W-1:0]});
    end else begin
      add_mag = $signed({{(WIDE_W-QMAG_W){1'b0}}, qmag});
    end
    add_out = neg ? add_base - add_mag : add_base + add_mag;
    sat_out = sat_q(add_out);
  end

  // difference to sign and magnitude for the multiplier
  always_comb begin
    case (state)
      S_PREP: begin
        dif_a = DIFF_W'(ct);
        dif_b = '0;
      end
      S_FCF: begin
        dif_a = vq[DIFF_W-1:0];
        dif_b = tmp;
      end
      default: begin
        dif_a = tmp;
        dif_b = DIFF_W'(ct);
      end
    endcase
    d_neg = dif_a < dif_b;
    d_mag = d_neg ? DIFF_W'(dif_b - dif_a) : DIFF_W'(dif_a - dif_b);
  end

  // residual truncated toward zero
  assign rsh   = tmp >>> FRAC_BITS;
  assign rcorr = tmp[DIFF_W-1] && (tmp[FRAC_BITS-1:0] != '0);
  assign rint  = rsh + $signed({{(DIFF_W-1){1'b0}}, rcorr});

  // multiplier commands
  always_comb begin
    mac_cmd = '0;
    mac_a   = cfg.trend_gain;
    mac_b   = mag[CHUNK_W-1:0];
    case (state)
      S_FC0, S_FC1: mac_a = {{(GAIN_W-HOR_W){1'b0}}, cfg.horizon};
      S_L0, S_L1:   mac_a = cfg.level_gain;
      default: ;
    endcase
    case (state)
      S_FC0: begin
        mac_cmd.en    = 1'b1;
        mac_cmd.start = 1'b1;
      end
      S_L0, S_T0: begin
        mac_cmd.en    = 1'b1;
        mac_cmd.start = 1'b1;
        mac_cmd.rnd   = 1'b1;
      end
      S_FC1, S_L1, S_T1: begin
        mac_cmd.en = 1'b1;
        mac_cmd.hi = 1'b1;
        mac_b      = mag[DIFF_W-1:CHUNK_W];
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stg       <= 1'b0;
      have_res  <= 1'b0;
      out_valid <= 1'b0;
      seen[0]   <= 2'd0;
      seen[1]   <= 2'd0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_LOAD;
            stg      <= 1'b0;
            have_res <= 1'b0;
            if (series_start) begin
              seen[0] <= 2'd0;
              seen[1] <= 2'd0;
            end
          end
        end
        S_LOAD:   state <= (seen[stg] == 2'd0) ? S_INIT : S_TRINIT;
        S_INIT: begin
          seen[stg] <= 2'd1;
          state     <= S_FIN;
        end
        S_TRINIT: state <= S_PREP;
        S_PREP:   state <= S_FC0;
        S_FC0:    state <= S_FC1;
        S_FC1:    state <= S_FCF;
        S_FCF:    state <= S_L0;
        S_L0:     state <= S_L1;
        S_L1:     state <= S_LF;
        S_LF:     state <= S_TD0;
        S_TD0:    state <= S_TD1;
        S_TD1:    state <= S_T0;
        S_T0:     state <= S_T1;
        S_T1:     state <= S_TF;
        S_TF: begin
          seen[stg] <= 2'd2;
          if (stg == cfg.residual_mode) begin
            have_res <= 1'b1;
          end
          state <= stg ? S_FIN : S_RES0;
        end
        S_RES0:   state <= S_RES1;
        S_RES1: begin
          stg   <= 1'b1;
          state <= S_LOAD;
        end
        S_FIN: begin
          if (!have_res) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          v <= VW'(sample);
        end
      end
      S_LOAD: begin
        cl <= lvl[stg];
        ct <= trd[stg];
        cp <= prv[stg];
      end
      S_INIT: begin
        lvl[stg] <= sat_q(vq);
        trd[stg] <= '0;
        prv[stg] <= v;
      end
      S_TRINIT: begin
        // second value of a series sets the trend
        if (seen[stg] == 2'd1) begin
          ct <= sat_q(trinit);
        end
      end
      S_PREP: begin
        tmp <= DIFF_W'(cl) + DIFF_W'(ct);
        mag <= d_mag;
        neg <= d_neg;
      end
      S_FCF: begin
        fc  <= sat_out;
        mag <= d_mag;
        neg <= d_neg;
      end
      S_LF:  nl  <= sat_out;
      S_TD0: tmp <= DIFF_W'(nl) - DIFF_W'(cl);
      S_TD1: begin
        mag <= d_mag;
        neg <= d_neg;
      end
      S_TF: begin
        lvl[stg] <= nl;
        trd[stg] <= sat_out;
        prv[stg] <= v;
        if (stg == cfg.residual_mode) begin
          res_fc <= fc;
          res_l  <= nl;
          res_t  <= sat_out;
        end
      end
      S_RES0: tmp <= DIFF_W'(fc) - cpq;
      S_RES1: v   <= VW'(sat_res(rint));
      S_FIN: begin
        if (have_res && out_free) begin
          forecast  <= res_fc;
          level_now <= res_l;
          trend_now <= res_t;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second beat while busy");

  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    seen[0] != 2'd3 && seen[1] != 2'd3)
    else $error("seen count beyond two");

  a_stage_two_order: assert property (@(posedge clk) disable iff (rst)
    state == S_TF && stg |-> seen[0] == 2'd2)
    else $error("stage two updated without a stage one forecast");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN && $past(have_res))
    else $error("output beat raised outside the finish step");
`endif

endmodule

`default_nettype wire

@@ rtl/holt_trend_forecaster_core.sv @@
// top level of the holt trend forecaster: apb registers, shared multiplier, sequencer
// depends on htf_pkg, htf_cfg, htf_mac and htf_seq
//
// channel   direction  handshake               payload
// apb       in/out     psel penable pready     paddr pwdata prdata
// in        in         in_valid in_ready       sample series_start
// out       out        out_valid out_ready     forecast level_now trend_now
//
// one beat at a time: in_ready is low from acceptance until the sequencer is back in idle.
// a sample on which both stages update is bound by the one 17x25 multiplier, which makes
// three products per stage in two passes each.
// the first sample of a series only initialises stage one and goes straight to the finish step.
// a result waits in the output register; the next beat is taken meanwhile and only its
// finish step stalls while out_valid is high and out_ready is low.
// synchronous reset puts registers at their reset values and both stages at empty.
`default_nettype none

module holt_trend_forecaster_core #(
  parameter int SAMPLE_BITS = htf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [htf_pkg::ADDR_W-1:0]     paddr,
  input  logic [htf_pkg::DATA_W-1:0]     pwdata,
  output logic [htf_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic                           series_start,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic signed [htf_pkg::Q_W-1:0] forecast,
  output logic signed [htf_pkg::Q_W-1:0] level_now,
  output logic signed [htf_pkg::Q_W-1:0] trend_now,
  output logic                           out_valid,
  input  logic                           out_ready
);
  import htf_pkg::*;

  cfg_t               cfg;
  mac_cmd_t           mac_cmd;
  logic [GAIN_W-1:0]  mac_a;
  logic [CHUNK_W-1:0] mac_b;
  logic [ACC_W-1:0]   mac_acc;

  htf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  htf_mac u_mac (
    .clk  (clk),
    .cmd  (mac_cmd),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  htf_seq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample       (sample),
    .series_start (series_start),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .forecast     (forecast),
    .level_now    (level_now),
    .trend_now    (trend_now),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mac_cmd      (mac_cmd),
    .mac_a        (mac_a),
    .mac_b        (mac_b),
    .mac_acc      (mac_acc)
  );

endmodule

`default_nettype wire

@@ verif/holt_trend_forecaster_core_tb.sv @@
// self-checking testbench for holt_trend_forecaster_core: a scoreboard class predicts each
// result of the two-stage holt smoother. needs htf_pkg and the core rtl, nothing else
module holt_trend_forecaster_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SW            = htf_pkg::SAMPLE_BITS_DEF;
  localparam int     QW            = htf_pkg::Q_W;
  localparam int     AW            = htf_pkg::ADDR_W;
  localparam longint UNITY_GAIN    = longint'(htf_pkg::GAIN_ONE);
  localparam longint Q_ONE         = longint'(1) <<< htf_pkg::FRAC_BITS;
  localparam int     SETTLE_CYCLES = 48;
  localparam int     HOLD_STRETCH  = 400;
  localparam int     PHASES        = 14;
  localparam int     PHASE_ITEMS   = 122;

  localparam int OPENING[13] = '{100, 300, 250, 32767, -32768, 32767, -32768, 0, -1,
                                 -32768, 32767, -32768, 32767};
  localparam int DOUBLING[6] = '{10, 20, 40, 80, 160, -5};
  localparam int SWINGS[5]   = '{1000, -1000, 32767, -32768, 7};

  typedef struct {
    logic signed [QW-1:0] forecast;
    logic signed [QW-1:0] level;
    logic signed [QW-1:0] trend;
  } holt_result_t;

  typedef struct {
    longint level;
    longint trend;
    longint prior;
    int     seen;
  } smoother_t;

  class forecast_ledger;
    longint       level_gain;
    longint       trend_gain;
    longint       horizon;
    bit           residual_mode;
    smoother_t    stage[2];
    holt_result_t due[$];
    int           samples_taken;
    int           results_seen;
    int           mismatches;

    function new();
      level_gain    = longint'(htf_pkg::LEVEL_GAIN_RST);
      trend_gain    = longint'(htf_pkg::TREND_GAIN_RST);
      horizon       = longint'(htf_pkg::HORIZON_RST);
      residual_mode = 1'b0;
      clear_stages();
    endfunction

    function void clear_stages();
      for (int k = 0; k < 2; k++) begin
        stage[k] = '{level: 0, trend: 0, prior: 0, seen: 0};
      end
    endfunction

    function void write_reg(logic [htf_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
      longint g;
      g = longint'(value[htf_pkg::GAIN_W-1:0]);
      case (idx)
        htf_pkg::REG_LEVEL_GAIN:    level_gain = (g > UNITY_GAIN) ? UNITY_GAIN : g;
        htf_pkg::REG_TREND_GAIN:    trend_gain = (g > UNITY_GAIN) ? UNITY_GAIN : g;
        htf_pkg::REG_HORIZON:       horizon = longint'(value[htf_pkg::HOR_W-1:0]);
        htf_pkg::REG_RESIDUAL_MODE: residual_mode = value[0];
        default: ;
      endcase
    endfunction

    function longint sat_to(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // d*g/65536 rounded half away from zero, split so nothing overflows
    function longint scale_by_gain(longint d, longint g);
      longint m;
      longint q;
      m = (d < 0) ? -d : d;
      q = g * (m / 65536) + (g * (m % 65536) + 32768) / 65536;
      return (d < 0) ? -q : q;
    endfunction

    function bit smooth_step(int k, longint v, output longint fc, output longint held);
      longint p;
      longint new_level;
      fc   = 0;
      held = 0;
      if (stage[k].seen == 0) begin
        stage[k].level = sat_to(v * Q_ONE, QW);
        stage[k].trend = 0;
        stage[k].prior = v;
        stage[k].seen  = 1;
        return 1'b0;
      end
      if (stage[k].seen == 1) begin
        stage[k].trend = sat_to((v - stage[k].prior) * Q_ONE, QW);
      end
      held = stage[k].prior;
      fc = sat_to(horizon * stage[k].trend + stage[k].level, QW);
      p = stage[k].level + stage[k].trend;
      new_level = sat_to(p + scale_by_gain(v * Q_ONE - p, level_gain), QW);
      stage[k].trend = sat_to(stage[k].trend + scale_by_gain((new_level - stage[k].level)
                              - stage[k].trend, trend_gain), QW);
      stage[k].level = new_level;
      stage[k].prior = v;
      stage[k].seen  = 2;
      return 1'b1;
    endfunction

    function void note_sample(logic signed [SW-1:0] x_in, logic start);
      longint       x;
      longint       fc1;
      longint       held1;
      longint       fc2;
      longint       held2;
      longint       d;
      bit           e1;
      bit           e2;
      int           k;
      holt_result_t res;
      x = x_in;
      e2 = 1'b0;
      fc2 = 0;
      samples_taken++;
      if (start) clear_stages();
      e1 = smooth_step(0, x, fc1, held1);
      if (e1) begin
        d = fc1 - held1 * Q_ONE;
        // signed division truncates toward zero
        e2 = smooth_step(1, sat_to(d / Q_ONE, htf_pkg::RES_W), fc2, held2);
      end
      if (residual_mode ? e2 : e1) begin
        k = residual_mode ? 1 : 0;
        res.forecast = residual_mode ? fc2 : fc1;
        res.level    = stage[k].level;
        res.trend    = stage[k].trend;
        due = {due, res};
      end
    endfunction

    function void check_result(logic signed [QW-1:0] fc, logic signed [QW-1:0] lv,
                               logic signed [QW-1:0] tr);
      holt_result_t want;
      results_seen++;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result forecast %0d level %0d trend %0d",
                   $time, fc, lv, tr);
        return;
      end
      want = due.pop_front();
      if (fc !== want.forecast || lv !== want.level || tr !== want.trend) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: result %0d: forecast exp %0d got %0d, ",
                    "level exp %0d got %0d, trend exp %0d got %0d"},
                   $time, results_seen, want.forecast, fc, want.level, lv, want.trend, tr);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AW-1:0]         paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic signed [SW-1:0]  sample;
  logic                  series_start;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [QW-1:0]  forecast;
  logic signed [QW-1:0]  level_now;
  logic signed [QW-1:0]  trend_now;
  logic                  out_valid;
  logic                  out_ready = 1'b0;

  forecast_ledger ledger;
  bit             tx_eager;
  bit             rx_eager;
  int             hold_cycles;
  int             settings_used;

  holt_trend_forecaster_core uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample       (sample),
    .series_start (series_start),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .forecast     (forecast),
    .level_now    (level_now),
    .trend_now    (trend_now),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) ledger.note_sample(sample, series_start);
      if (out_valid && out_ready) ledger.check_result(forecast, level_now, trend_now);
    end
  end

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    int wait_n;
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      wait_n = rx_eager ? 0 : $urandom_range(0, 7);
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #8_000_000;
    $display("holt_trend_forecaster_core verification failed");
    $finish;
  end

  task automatic send_sample(int x, logic start);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample       <= SW'(x);
    series_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // waits out every pending result, then the tail of a possibly silent beat
  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves the bus asserted so back-to-back writes need no extra step
  task automatic reg_write(logic [htf_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ledger.write_reg(idx, value);
  endtask

  task automatic configure(int lg, int tg, int hor, int mode, bit junk);
    logic [31:0] upper;
    settle();
    upper = junk ? $urandom : 32'h0;
    reg_write(htf_pkg::REG_LEVEL_GAIN, (upper & 32'hFFFE_0000) | 32'(lg));
    reg_write(htf_pkg::REG_TREND_GAIN, (upper & 32'hFFFE_0000) | 32'(tg));
    reg_write(htf_pkg::REG_HORIZON, (upper & 32'hFFFF_FFF0) | 32'(hor));
    reg_write(htf_pkg::REG_RESIDUAL_MODE, (upper & 32'hFFFF_FFFE) | 32'(mode));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  // one series with a random shape; rare stray starts and missing starts as noise
  task automatic run_series(int len, logic with_start, inout int sent);
    int shape;
    int base;
    int slope;
    int v;
    logic start;
    shape = $urandom_range(0, 3);
    base  = int'($urandom_range(0, 65535)) - 32768;
    slope = int'($urandom_range(0, 400)) - 200;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: v = int'($urandom_range(0, 65535)) - 32768;
        1: v = base + slope * i + int'($urandom_range(0, 64)) - 32;
        2: v = $urandom_range(0, 1) ? 32767 : -32768;
        default: v = int'($urandom_range(0, 15)) - 8;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      start = (i == 0) ? with_start : ($urandom_range(0, 49) == 0);
      send_sample(v, start);
      sent++;
    end
  endtask

  initial begin
    int sent;
    int lg;
    int tg;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample       = '0;
    series_start = 1'b0;
    in_valid     = 1'b0;
    tx_eager     = 1'b0;
    rx_eager     = 1'b0;
    hold_cycles  = 0;
    sent         = 0;
    ledger = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings; first series has no start mark, then a fresh one at the extremes
    foreach (OPENING[i]) send_sample(OPENING[i], i == 9);
    // unit gains, horizon zero, residual stage reporting
    configure(65536, 65536, 0, 1, 1'b0);
    foreach (DOUBLING[i]) send_sample(DOUBLING[i], i == 0);
    // level gain above one, trend frozen, longest horizon
    configure(131071, 0, 15, 0, 1'b0);
    foreach (SWINGS[i]) send_sample(SWINGS[i], i == 0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(0, 0, 15, 0, 1'b0);
        1: configure(65536, 65536, 1, 1, 1'b0);
        2: configure(1, 65535, 0, 1, 1'b0);
        3: configure(131071, 131071, 15, 1, 1'b0);
        default: begin
          lg = ($urandom_range(0, 3) == 0) ? $urandom_range(65537, 131071)
                                           : $urandom_range(0, 65536);
          tg = ($urandom_range(0, 3) == 0) ? $urandom_range(65537, 131071)
                                           : $urandom_range(0, 65536);
          configure(lg, tg, $urandom_range(0, 15), $urandom_range(0, 1), 1'b1);
        end
      endcase
      tx_eager = (p % 4 == 1) || (p == 5);
      rx_eager = (p % 4 == 1) || (p % 4 == 2);
      if (p == 5) hold_cycles = HOLD_STRETCH;
      sent = 0;
      while (sent < PHASE_ITEMS)
        run_series($urandom_range(1, 40), $urandom_range(0, 9) != 0, sent);
    end

    settle();
    $display("covered %0d samples, %0d results checked across %0d register settings",
             ledger.samples_taken, ledger.results_seen, settings_used);
    $display("mismatching results: %0d", ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.due.size() == 0) begin
      $display("holt_trend_forecaster_core verification clean");
    end else begin
      $display("holt_trend_forecaster_core verification failed");
    end
    $finish;
  end

endmodule
